### rtl/dnsbf_pkg.sv
package dnsbf_pkg;

  localparam int unsigned OFF_W = 11;

  // Frame offsets and field values checked on the fly.
  localparam logic [OFF_W-1:0] OFF_MAX        = 11'd2047;
  localparam logic [OFF_W-1:0] OFF_ETYPE_HI   = 11'd12;
  localparam logic [OFF_W-1:0] OFF_ETYPE_LO   = 11'd13;
  localparam logic [OFF_W-1:0] OFF_FRAG_HI    = 11'd20;
  localparam logic [OFF_W-1:0] OFF_FRAG_LO    = 11'd21;
  localparam logic [OFF_W-1:0] OFF_PROTO      = 11'd23;
  localparam logic [OFF_W-1:0] OFF_DPORT_HI   = 11'd36;
  localparam logic [OFF_W-1:0] OFF_DPORT_LO   = 11'd37;
  localparam logic [OFF_W-1:0] OFF_DNS_FLAGS  = 11'd44;
  localparam logic [OFF_W-1:0] OFF_DNS_START  = 11'd42;
  localparam logic [OFF_W-1:0] OFF_NAME_FIRST = 11'd54;
  localparam logic [OFF_W-1:0] OFF_MIN_LAST   = 11'd53;
  localparam logic [6:0]       NAME_REL_START = 7'd12;

  localparam logic [7:0] ETYPE_HI     = 8'h08;
  localparam logic [7:0] ETYPE_LO     = 8'h00;
  localparam logic [7:0] FRAG_HI_MASK = 8'h3F;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] QR_MASK      = 8'h80;
  localparam logic [7:0] NAME_DOT     = 8'h2E;

  localparam logic [15:0] DNS_PORT_RESET = 16'd53;

  // Result queue depth; also the bound on results in flight.
  localparam int unsigned       QDEPTH   = 4;
  localparam int unsigned       QPTR_W   = 2;
  localparam logic [QPTR_W:0]   QDEPTH_C = 3'd4;

  typedef struct packed {
    logic [31:0] name_hash;
    logic [5:0]  name_length;
    logic        checked;
  } frame_res_t;

endpackage

### rtl/dnsbf_ram.sv
module dnsbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/dnsbf_parser.sv
module dnsbf_parser #(
  parameter int unsigned NAME_LIMIT = 63
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   frame_valid_i,
  input  logic [7:0]             byte_i,
  input  logic                   last_i,
  input  logic [15:0]            dns_port_i,
  output logic                   res_valid_o,
  output dnsbf_pkg::frame_res_t  res_o
);
  import dnsbf_pkg::*;

  localparam int unsigned CW = $clog2(NAME_LIMIT + 1);
  localparam int unsigned LW = $clog2(2 * NAME_LIMIT + 2);

  logic [OFF_W-1:0] off_q, off_d;
  logic             hdr_ok_q, hdr_ok_d;
  logic [7:0]       port_hi_q, port_hi_d;
  logic [31:0]      hash_q, hash_d;
  logic [CW-1:0]    chars_q, chars_d;
  logic [LW-1:0]    lpos_q, lpos_d;
  logic [7:0]       left_q, left_d;
  logic             done_q, done_d;
  logic             res_valid_q, res_valid_d;
  frame_res_t       res_q, res_d;

  logic [OFF_W-1:0] rel;
  logic             app;
  logic [7:0]       app_char;
  logic             checked;

  always_comb begin
    off_d       = off_q;
    hdr_ok_d    = hdr_ok_q;
    port_hi_d   = port_hi_q;
    hash_d      = hash_q;
    chars_d     = chars_q;
    lpos_d      = lpos_q;
    left_d      = left_q;
    done_d      = done_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    app         = 1'b0;
    app_char    = byte_i;
    checked     = 1'b0;
    rel         = off_q - OFF_DNS_START;

    if (frame_valid_i) begin
      if (off_q == OFF_ETYPE_HI && byte_i != ETYPE_HI) hdr_ok_d = 1'b0;
      if (off_q == OFF_ETYPE_LO && byte_i != ETYPE_LO) hdr_ok_d = 1'b0;
      if (off_q == OFF_FRAG_HI && (byte_i & FRAG_HI_MASK) != 8'd0) hdr_ok_d = 1'b0;
      if (off_q == OFF_FRAG_LO && byte_i != 8'd0) hdr_ok_d = 1'b0;
      if (off_q == OFF_PROTO && byte_i != PROTO_UDP) hdr_ok_d = 1'b0;
      if (off_q == OFF_DPORT_HI) port_hi_d = byte_i;
      if (off_q == OFF_DPORT_LO && {port_hi_q, byte_i} != dns_port_i) hdr_ok_d = 1'b0;
      if (off_q == OFF_DNS_FLAGS && (byte_i & QR_MASK) != 8'd0) hdr_ok_d = 1'b0;

      if (hdr_ok_d && off_q >= OFF_NAME_FIRST && off_q < OFF_MAX && !done_q) begin
        if (left_q != 8'd0) begin
          // Inside a label: keep characters while the name window lasts.
          if (rel < OFF_W'(NAME_LIMIT + 1)) begin
            app    = 1'b1;
            left_d = left_q - 8'd1;
          end else begin
            done_d = 1'b1;
          end
        end else if (rel == OFF_W'(lpos_q)) begin
          if (rel >= OFF_W'(NAME_LIMIT) || byte_i == 8'd0 ||
              (10'(chars_q) + 10'(byte_i) + 10'd1) > 10'(NAME_LIMIT)) begin
            done_d = 1'b1;
          end else begin
            // Labels after the first are joined by a dot.
            if (chars_q != '0) begin
              app      = 1'b1;
              app_char = NAME_DOT;
            end
            left_d = byte_i;
            lpos_d = LW'(rel + OFF_W'(byte_i) + 11'd1);
          end
        end
      end

      if (app) begin
        hash_d  = (hash_q << 5) - hash_q + 32'(app_char);
        chars_d = chars_q + CW'(1);
      end

      if (off_q != OFF_MAX) off_d = off_q + 11'd1;

      if (last_i) begin
        checked           = hdr_ok_d && off_q >= OFF_MIN_LAST;
        res_valid_d       = 1'b1;
        res_d.checked     = checked;
        res_d.name_length = checked ? 6'(chars_d) : 6'd0;
        res_d.name_hash   = checked ? hash_d : 32'd0;
        off_d             = '0;
        hdr_ok_d          = 1'b1;
        port_hi_d         = 8'd0;
        hash_d            = 32'd0;
        chars_d           = '0;
        lpos_d            = LW'(NAME_REL_START);
        left_d            = 8'd0;
        done_d            = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q       <= '0;
      hdr_ok_q    <= 1'b1;
      port_hi_q   <= 8'd0;
      hash_q      <= 32'd0;
      chars_q     <= '0;
      lpos_q      <= LW'(NAME_REL_START);
      left_q      <= 8'd0;
      done_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      off_q       <= off_d;
      hdr_ok_q    <= hdr_ok_d;
      port_hi_q   <= port_hi_d;
      hash_q      <= hash_d;
      chars_q     <= chars_d;
      lpos_q      <= lpos_d;
      left_q      <= left_d;
      done_q      <= done_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### rtl/dns_query_bloom_classifier_core.sv
// The result of a frame is registered in the parser, then in the bloom read stage, then queued.
// One item per cycle while s_axis_tready is high; a four-entry result queue absorbs sink stalls.
// The bloom table is read once per frame through the read port of a single RAM.
// Reset: after rst_ni is released the bloom RAM is cleared one byte per cycle,
// over all BLOOM_BYTES entries, with s_axis_tready low; dns_port returns to 53.
module dns_query_bloom_classifier_core #(
  parameter int unsigned BLOOM_BYTES = 131072,
  parameter int unsigned NAME_LIMIT  = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // frame_byte [7:0], bloom_index [24:8], bloom_value [32:25], zero [39:33]
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  // action [0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // verdict [0], dns_checked [1], name_length [7:2], name_hash [39:8]
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import dnsbf_pkg::*;

  // The bloom table must hold a power of two of bytes.
  localparam int unsigned AW = $clog2(BLOOM_BYTES);

  logic [15:0]        dns_port_q;
  logic               clr_q;
  logic [AW-1:0]      clr_cnt_q;
  logic               in_acc, frame_acc, bloom_acc, last_acc;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [7:0]         ram_wdata, ram_rdata;
  logic               res_valid;
  frame_res_t         res;
  logic               p2_valid_q;
  frame_res_t         p2_res_q;
  logic [2:0]         p2_bit_q;
  logic               verdict;
  logic [39:0]        fifo_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]    fcnt_q, pend_q;
  logic               pop;
  logic [16:0]        bloom_index;

  assign bloom_index   = s_axis_tdata[24:8];
  assign s_axis_tready = !clr_q && pend_q != QDEPTH_C;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign frame_acc     = in_acc && !s_axis_tuser;
  assign bloom_acc     = in_acc && s_axis_tuser && 21'(bloom_index) < 21'(BLOOM_BYTES);
  assign last_acc      = frame_acc && s_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dns_port_q <= DNS_PORT_RESET;
    end else if (cfg_we_i) begin
      dns_port_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(BLOOM_BYTES - 1)) clr_q <= 1'b0;
    end
  end

  assign ram_we    = clr_q || bloom_acc;
  assign ram_waddr = clr_q ? clr_cnt_q : AW'(bloom_index);
  assign ram_wdata = clr_q ? 8'd0 : s_axis_tdata[32:25];

  dnsbf_parser #(
    .NAME_LIMIT (NAME_LIMIT)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_acc),
    .byte_i        (s_axis_tdata[7:0]),
    .last_i        (s_axis_tlast),
    .dns_port_i    (dns_port_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // A bloom write taken in the cycle of the lookup belongs to a later point in
  // the stream, so the read-old behaviour of the RAM is what is wanted.
  dnsbf_ram #(
    .WIDTH (8),
    .DEPTH (BLOOM_BYTES)
  ) u_bloom_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (res.name_hash[AW+2:3]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else begin
      p2_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_res_q <= res;
    p2_bit_q <= res.name_hash[2:0];
  end

  assign verdict = p2_res_q.checked && ram_rdata[p2_bit_q];
  assign pop     = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (p2_valid_q) begin
      fifo_q[wr_ptr_q] <= {p2_res_q.name_hash, p2_res_q.name_length,
                           p2_res_q.checked, verdict};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fcnt_q   <= '0;
      pend_q   <= '0;
    end else begin
      if (p2_valid_q) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      fcnt_q <= fcnt_q + (QPTR_W+1)'(p2_valid_q) - (QPTR_W+1)'(pop);
      pend_q <= pend_q + (QPTR_W+1)'(last_acc) - (QPTR_W+1)'(pop);
    end
  end

  assign m_axis_tvalid = fcnt_q != '0;
  assign m_axis_tdata  = fifo_q[rd_ptr_q];

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready)
    else $error("input accepted during bloom clear");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= QDEPTH_C && fcnt_q <= pend_q)
    else $error("result accounting out of range");

  a_last_to_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_acc |-> ##2 p2_valid_q)
    else $error("frame result did not reach the queue");

  a_verdict_checked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
    else $error("drop verdict on an unchecked frame");
`endif

endmodule
